[hw/rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising edge of clk_i outside reset.
`define LEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition never holds.
`define LEB_ASSERT_NEVER(lbl, cond, msg) \
  `LEB_ASSERT(lbl, !(cond), msg)

`endif

[hw/rtl/leb_pkg.sv]
// -----------------------------------------------------------------------------
// Line edit buffer package
// Shared widths, register codes, reset values, state and control types.
// -----------------------------------------------------------------------------
package leb_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERASE      = 3'd0,
    CFG_KILL       = 3'd1,
    CFG_ENTER      = 3'd2,
    CFG_SUBST_FROM = 3'd3,
    CFG_SUBST_TO   = 3'd4
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] ERASE_RST      = 8'd88;
  localparam logic [BYTE_W-1:0] KILL_RST       = 8'd75;
  localparam logic [BYTE_W-1:0] ENTER_RST      = 8'd69;
  localparam logic [BYTE_W-1:0] SUBST_FROM_RST = 8'd97;
  localparam logic [BYTE_W-1:0] SUBST_TO_RST   = 8'd122;
  localparam logic [BYTE_W-1:0] NUL_BYTE       = 8'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_OUT,
    S_EMPTY
  } leb_state_e;

  typedef struct packed {
    logic cap_byte;
    logic edit;
    logic rd_issue;
    logic out_load_char;
    logic out_load_empty;
    logic clear_line;
    logic idx_inc;
  } leb_cmd_t;

  typedef struct packed {
    logic is_enter;
    logic fill_zero;
    logic is_last;
    logic out_free;
  } leb_sts_t;

endpackage

[hw/rtl/leb_if.sv]
// -----------------------------------------------------------------------------
// Line edit buffer channels
// Valid/ready channels for input bytes, emitted characters and register writes.
// -----------------------------------------------------------------------------
interface leb_in_if import leb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface leb_out_if import leb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_char;
  logic              last_char;
  logic              empty_line;
  logic              overflowed;

  modport source (output valid, output out_char, output last_char, output empty_line,
                  output overflowed, input ready);
  modport sink (input valid, input out_char, input last_char, input empty_line,
                input overflowed, output ready);
endinterface

interface leb_cfg_if import leb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/leb_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/leb_datapath.sv]
// -----------------------------------------------------------------------------
// Line edit buffer datapath
// Registers, line store, fill count, edit logic and the output register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module leb_datapath import leb_pkg::*; #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  leb_cmd_t             cmd_i,
  output leb_sts_t             sts_o,
  input  logic [BYTE_W-1:0]    in_byte_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    out_char_o,
  output logic                 last_char_o,
  output logic                 empty_line_o,
  output logic                 overflowed_o
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);

  logic [BYTE_W-1:0] erase_q, kill_q, enter_q, subst_from_q, subst_to_q;
  logic [BYTE_W-1:0] byte_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              ended_q, ended_d;
  logic              drop_q, drop_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              we;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] rdata;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_char_q;
  logic              last_q, empty_q, ovf_q;
  logic              full;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q      <= ERASE_RST;
      kill_q       <= KILL_RST;
      enter_q      <= ENTER_RST;
      subst_from_q <= SUBST_FROM_RST;
      subst_to_q   <= SUBST_TO_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ERASE:      erase_q      <= cfg_data_i;
        CFG_KILL:       kill_q       <= cfg_data_i;
        CFG_ENTER:      enter_q      <= cfg_data_i;
        CFG_SUBST_FROM: subst_from_q <= cfg_data_i;
        CFG_SUBST_TO:   subst_to_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_byte) begin
      byte_q <= in_byte_i;
    end
  end

  assign full     = (fill_q == CNT_W'(LINE_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;

  // Edit the line on a decoded non-enter byte; clear it after emission.
  always_comb begin
    fill_d   = fill_q;
    ended_d  = ended_q;
    drop_d   = drop_q;
    rd_idx_d = rd_idx_q;
    we       = 1'b0;
    wdata    = byte_q;
    if (cmd_i.edit && !ended_q) begin
      if (byte_q == NUL_BYTE) begin
        ended_d = 1'b1;
      end else if (byte_q != subst_from_q && byte_q == erase_q) begin
        if (fill_q != '0) begin
          fill_d = fill_q - CNT_W'(1);
        end
      end else if (byte_q != subst_from_q && byte_q == kill_q) begin
        fill_d = '0;
      end else begin
        wdata = (byte_q == subst_from_q) ? subst_to_q : byte_q;
        if (full) begin
          drop_d = 1'b1;
        end else begin
          we     = 1'b1;
          fill_d = fill_q + CNT_W'(1);
        end
      end
    end
    if (cmd_i.idx_inc) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
    end
    if (cmd_i.clear_line) begin
      fill_d   = '0;
      ended_d  = 1'b0;
      drop_d   = 1'b0;
      rd_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      ended_q  <= 1'b0;
      drop_q   <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      fill_q   <= fill_d;
      ended_q  <= ended_d;
      drop_q   <= drop_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  leb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load_char || cmd_i.out_load_empty) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_char) begin
      out_char_q <= rdata;
      last_q     <= sts_o.is_last;
      empty_q    <= 1'b0;
      ovf_q      <= drop_q;
    end else if (cmd_i.out_load_empty) begin
      out_char_q <= NUL_BYTE;
      last_q     <= 1'b1;
      empty_q    <= 1'b1;
      ovf_q      <= drop_q;
    end
  end

  assign sts_o.is_enter  = (byte_q == enter_q);
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.is_last   = (CNT_W'(rd_idx_q) + CNT_W'(1) == fill_q);
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign last_char_o  = last_q;
  assign empty_line_o = empty_q;
  assign overflowed_o = ovf_q;

  `LEB_ASSERT(a_fill_bound, fill_q <= CNT_W'(LINE_DEPTH), "fill count beyond line depth")
  `LEB_ASSERT(a_load_free, (cmd_i.out_load_char || cmd_i.out_load_empty) |-> out_free, "output register overwritten while held")
  `LEB_ASSERT(a_clear, cmd_i.clear_line |=> (fill_q == '0 && !drop_q && !ended_q), "line state not cleared after emission")

endmodule

[hw/rtl/leb_ctrl.sv]
// -----------------------------------------------------------------------------
// Line edit buffer controller
// Sequences byte capture, line editing and character-by-character emission.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module leb_ctrl import leb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  leb_sts_t sts_i,
  output leb_cmd_t cmd_o
);

  leb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_byte = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_enter) begin
          cmd_o.edit = 1'b1;
          state_d    = S_IDLE;
        end else if (sts_i.fill_zero) begin
          state_d = S_EMPTY;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load_char = 1'b1;
          if (sts_i.is_last) begin
            cmd_o.clear_line = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load_empty = 1'b1;
          cmd_o.clear_line     = 1'b1;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `LEB_ASSERT(a_rd_then_out, cmd_o.rd_issue |=> (state_q == S_OUT), "read data not consumed next")
  `LEB_ASSERT_NEVER(a_edit_on_enter, cmd_o.edit && sts_i.is_enter, "enter byte applied as an edit")

endmodule

[hw/rtl/line_edit_buffer.sv]
// -----------------------------------------------------------------------------
// Line edit buffer
// Keeps an edited keyboard line and emits it one character per transaction.
//
// Channels: in_i takes one raw byte per transaction; out_o returns the
// characters of a finished line with last_char on the final one, or a single
// transaction with empty_line set for a line without characters; cfg_i writes
// the erase, kill, enter and substitute codes (index 0 to 4, others ignored)
// and is always ready. Write cfg_i only while the block is idle.
// Sequence: a non-enter byte is captured and then edited, and in_i is ready
// again once the edit is done. An enter is decoded, then each character is
// read from the line store through its registered read port and loaded into
// the output register; the next character is read only after that load.
// The output register lets the next byte be accepted while the final
// character still waits. A stalled receiver holds emission of the line.
// Reset empties the line and restores the default codes; the line store
// itself needs no clearing.
// -----------------------------------------------------------------------------
module line_edit_buffer import leb_pkg::*; #(
  parameter int LINE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  leb_in_if.sink    in_i,
  leb_out_if.source out_o,
  leb_cfg_if.sink   cfg_i
);

  leb_cmd_t cmd;
  leb_sts_t sts;

  assign cfg_i.ready = 1'b1;

  leb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  leb_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (in_i.in_byte),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_char_o   (out_o.out_char),
    .last_char_o  (out_o.last_char),
    .empty_line_o (out_o.empty_line),
    .overflowed_o (out_o.overflowed)
  );

endmodule
